// ----- design/tcrg_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcrg_pkg
// Shared constants of the text cell row generator: field widths, opcodes,
// attribute bits and the character/attribute pairs that blank to a space.
// ----------------------------------------------------------------------------
package tcrg_pkg;

  // Default glyph geometry
  localparam int GlyphWidthDef  = 5;
  localparam int GlyphHeightDef = 9;

  // Fixed field widths
  localparam int CharW     = 8;
  localparam int AttrW     = 8;
  localparam int CellRowW  = 4;
  localparam int PixelRowW = 12;
  localparam int MosaicW   = 6;
  localparam int GlyphIdxW = 7;

  // Request opcodes
  localparam logic OpRender = 1'b0;
  localparam logic OpLoad   = 1'b1;

  // Attribute bits
  localparam int AttrUnderBit = 1;
  localparam int AttrRevBit   = 3;

  // Substitution pairs
  localparam logic [CharW-1:0] ChrNull  = 8'h00;
  localparam logic [CharW-1:0] ChrFour  = 8'h04;
  localparam logic [CharW-1:0] ChrHigh  = 8'h80;
  localparam logic [CharW-1:0] ChrSpace = 8'h20;
  localparam logic [AttrW-1:0] AttrNone = 8'h00;
  localparam logic [AttrW-1:0] AttrFour = 8'h04;
  localparam logic [AttrW-1:0] AttrRev  = 8'h08;

  // Mosaic bands: top rows 0-2, middle 3-5, bottom 6-9
  localparam int MosaicMidRow = 3;
  localparam int MosaicBotRow = 6;
  localparam int MosaicEndRow = 10;
  localparam int MosaicRightCol = 3;

endpackage
`default_nettype wire

// ----- design/text_cell_row_generator_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// text_cell_row_generator_top
// Character generator: one pixel row of a text or mosaic cell per request.
// ----------------------------------------------------------------------------
// Usage
// - Input channel (in_valid_i/in_ready_o): opcode_i selects render or font
//   load. A render request returns exactly one pixel_row_o; a load writes one
//   font row (rows at or above the glyph height are dropped) and returns none.
// - Output channel (out_valid_o/out_ready_i): one pixel row per render.
// - Config channel (cfg_valid_i/cfg_ready_o, wide_mode_i): always ready;
//   write it only while no render is in flight.
// - Pipeline: stage one does the blank-pair substitution and reads the font
//   RAM (registered read); stage two builds the pixels, doubles them in
//   narrow mode and loads the output register.
// - Throughput: one request per cycle while the output is not stalled; the
//   single-port font RAM sees at most one read or one write per cycle, which
//   sets that figure.
// - Reset clears the pipeline valids and sets wide mode. The font RAM is not
//   cleared: load every glyph row before rendering it.
// - Output stall: both stages hold; in_ready_o drops only when both are full.
// ----------------------------------------------------------------------------
module text_cell_row_generator_top #(
  parameter int GlyphWidth  = tcrg_pkg::GlyphWidthDef,
  parameter int GlyphHeight = tcrg_pkg::GlyphHeightDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           wide_mode_i,
  // requests
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           opcode_i,
  input  logic [tcrg_pkg::CharW-1:0]     char_code_i,
  input  logic [tcrg_pkg::AttrW-1:0]     attr_code_i,
  input  logic [tcrg_pkg::CellRowW-1:0]  cell_row_i,
  input  logic [GlyphWidth-1:0]          font_bits_i,
  // results
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tcrg_pkg::PixelRowW-1:0] pixel_row_o
);
  import tcrg_pkg::*;

  localparam int CellW     = GlyphWidth + 1;
  localparam int FontDepth = 128 * GlyphHeight;
  localparam int AddrW     = $clog2(FontDepth);
  localparam int DblW      = (2 * CellW > PixelRowW) ? 2 * CellW : PixelRowW;
  localparam logic [CellRowW-1:0] RowGlyphH  = CellRowW'(GlyphHeight);
  localparam logic [CellRowW-1:0] RowUnder   = CellRowW'(GlyphHeight - 1);
  localparam logic [CellRowW-1:0] RowMosMid  = CellRowW'(MosaicMidRow);
  localparam logic [CellRowW-1:0] RowMosBot  = CellRowW'(MosaicBotRow);
  localparam logic [CellRowW-1:0] RowMosEnd  = CellRowW'(MosaicEndRow);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic wide_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q <= 1'b1;
    end else if (cfg_valid_i) begin
      wide_q <= wide_mode_i;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: stage one advances whenever the output register frees up
  // --------------------------------------------------------------------------
  logic s1_valid_q;
  logic out_valid_q;
  logic out_adv;
  logic s1_adv;
  logic in_acc;

  assign out_adv    = !out_valid_q || out_ready_i;
  assign s1_adv     = !s1_valid_q || out_adv;
  assign in_ready_o = s1_adv;
  assign in_acc     = in_valid_i && s1_adv;

  // --------------------------------------------------------------------------
  // Stage one: substitution, address, font RAM access
  // --------------------------------------------------------------------------
  logic                 sub_blank;
  logic                 sub_rev;
  logic [CharW-1:0]     chr_eff;
  logic [AttrW-1:0]     attr_eff;
  logic                 is_text;
  logic                 row_ok;
  logic [AddrW-1:0]     mem_addr;
  logic                 mem_we;
  logic                 mem_re;

  always_comb begin
    // Blank pairs turn into a space, plain or reversed
    sub_blank = (char_code_i == ChrHigh && attr_code_i == AttrFour) ||
                (char_code_i == ChrNull && attr_code_i == AttrNone) ||
                (char_code_i == ChrFour && attr_code_i == AttrFour);
    sub_rev   = (char_code_i == ChrNull && attr_code_i == AttrRev) ||
                (char_code_i == ChrFour && attr_code_i == AttrRev);
    priority if (sub_blank) begin
      chr_eff  = ChrSpace;
      attr_eff = AttrNone;
    end else if (sub_rev) begin
      chr_eff  = ChrSpace;
      attr_eff = AttrRev;
    end else begin
      chr_eff  = char_code_i;
      attr_eff = attr_code_i;
    end
  end

  // Loads use the raw code; renders the substituted one
  logic [GlyphIdxW-1:0] glyph_idx;

  assign is_text   = !chr_eff[CharW-1] && (chr_eff != ChrNull);
  assign row_ok    = cell_row_i < RowGlyphH;
  assign glyph_idx = (opcode_i == OpLoad) ? char_code_i[GlyphIdxW-1:0]
                                          : chr_eff[GlyphIdxW-1:0];
  assign mem_addr  = AddrW'(glyph_idx) * AddrW'(GlyphHeight) + AddrW'(cell_row_i);
  assign mem_we    = in_acc && (opcode_i == OpLoad) && row_ok;
  assign mem_re    = in_acc && (opcode_i == OpRender) && is_text && row_ok;

  logic [GlyphWidth-1:0] font_mem [FontDepth];
  logic [GlyphWidth-1:0] glyph_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      font_mem[mem_addr] <= font_bits_i;
    end else if (mem_re) begin
      glyph_q <= font_mem[mem_addr];
    end
  end

  logic                s1_text_q;
  logic                s1_under_q;
  logic                s1_rev_q;
  logic [CellRowW-1:0] s1_row_q;
  logic [MosaicW-1:0]  s1_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= in_valid_i && (opcode_i == OpRender);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_text_q  <= is_text;
      s1_under_q <= attr_eff[AttrUnderBit];
      s1_rev_q   <= attr_eff[AttrRevBit];
      s1_row_q   <= cell_row_i;
      s1_code_q  <= chr_eff[MosaicW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage two: pixel build, doubling, output register
  // --------------------------------------------------------------------------
  logic [CellW-1:0]     px;
  logic [1:0]           band;
  logic                 under_row;
  logic                 lit;
  logic [DblW-1:0]      dbl;
  logic [DblW-1:0]      px_ext;
  logic [PixelRowW-1:0] pixel_d;

  always_comb begin
    px        = '0;
    lit       = 1'b0;
    under_row = s1_under_q && (s1_row_q == RowUnder);
    // Mosaic band: left and right block bits for this row
    if (s1_row_q < RowMosMid) begin
      band = s1_code_q[1:0];
    end else if (s1_row_q < RowMosBot) begin
      band = s1_code_q[3:2];
    end else if (s1_row_q < RowMosEnd) begin
      band = s1_code_q[5:4];
    end else begin
      band = 2'b00;
    end

    if (s1_text_q) begin
      if (s1_row_q < RowGlyphH) begin
        for (int c = 0; c < GlyphWidth; c++) begin
          lit = glyph_q[GlyphWidth-1-c] ^ s1_rev_q;
          if (under_row) begin
            lit = !s1_rev_q;
          end
          px[CellW-1-c] = lit;
        end
        px[0] = s1_rev_q || under_row;
      end
    end else if (!(s1_row_q > RowGlyphH || (!wide_q && s1_row_q == RowGlyphH))) begin
      for (int c = 0; c < GlyphWidth; c++) begin
        if (c < MosaicRightCol) begin
          px[CellW-1-c] = band[0];
        end else if (c < 2 * MosaicRightCol) begin
          px[CellW-1-c] = band[1];
        end
      end
    end

    // 40-column mode doubles each pixel
    dbl = '0;
    for (int c = 0; c < CellW; c++) begin
      dbl[2*c]   = px[c];
      dbl[2*c+1] = px[c];
    end
    px_ext  = DblW'(px);
    pixel_d = wide_q ? px_ext[PixelRowW-1:0] : dbl[PixelRowW-1:0];
  end

  logic [PixelRowW-1:0] pixel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      pixel_q <= pixel_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_row_o = pixel_q;

endmodule
`default_nettype wire

// ----- design/tcrg_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcrg_checker
// Port-level checks of the text cell row generator, bound to the top level.
// ----------------------------------------------------------------------------
module tcrg_checker #(
  parameter int GlyphWidth = tcrg_pkg::GlyphWidthDef
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic                           wide_mode_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [tcrg_pkg::PixelRowW-1:0] pixel_row_o
);
  import tcrg_pkg::*;

  localparam int CellW = GlyphWidth + 1;
  localparam logic [PixelRowW-1:0] PairMask = {(PixelRowW / 2){2'b01}};

  // Mirror of the mode register as seen on the config channel
  logic wide_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      wide_q <= wide_mode_i;
    end
  end

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_row_o))
    else $error("result dropped or changed while stalled");

  // Input is refused only when the output is full and stalled
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input refused with room in the pipeline");

  // Wide mode uses only the cell's columns
  a_wide_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && wide_q |-> (pixel_row_o >> CellW) == '0)
    else $error("wide-mode pixels beyond the cell");

  // Narrow mode doubles every pixel
  a_narrow_pairs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !wide_q |-> ((pixel_row_o ^ (pixel_row_o >> 1)) & PairMask) == '0)
    else $error("narrow-mode pixel pair split");

endmodule

bind text_cell_row_generator_top tcrg_checker #(
  .GlyphWidth (GlyphWidth)
) u_tcrg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .wide_mode_i (wide_mode_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .pixel_row_o (pixel_row_o)
);
`default_nettype wire

// ----- tb/text_cell_row_checker.sv -----
// ----------------------------------------------------------------------------
// text_cell_row_checker
// Watches the config, request and pixel row channels of the cell row
// generator, keeps its own font rows and wide mode, works out each render's
// pixel row and compares it in order with what the block returns.
// ----------------------------------------------------------------------------
module text_cell_row_checker #(
  parameter int GlyphWidth  = tcrg_pkg::GlyphWidthDef,
  parameter int GlyphHeight = tcrg_pkg::GlyphHeightDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic                           wide_mode_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic                           opcode_i,
  input  logic [tcrg_pkg::CharW-1:0]     char_code_i,
  input  logic [tcrg_pkg::AttrW-1:0]     attr_code_i,
  input  logic [tcrg_pkg::CellRowW-1:0]  cell_row_i,
  input  logic [GlyphWidth-1:0]          font_bits_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [tcrg_pkg::PixelRowW-1:0] pixel_row_i,
  output int                             rows_pending_o,
  output int                             fail_count_o
);
  import tcrg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CellW = GlyphWidth + 1;

  logic                  wide_q;
  logic [GlyphWidth-1:0] font_rows [128*GlyphHeight];
  logic [PixelRowW-1:0]  pending_rows [$];
  logic [PixelRowW-1:0]  want_row;
  int                    fails = 0;

  assign fail_count_o = fails;

  task automatic report_mismatch(input string what, input logic [PixelRowW-1:0] got,
                                 input logic [PixelRowW-1:0] want);
    fails++;
    $display("%0t ns: pixel row error (%s): got %03h, want %03h", $realtime, what, got, want);
  endtask

  function automatic logic [PixelRowW-1:0] cell_pixel_row(input logic [CharW-1:0] chr_raw,
                                                          input logic [AttrW-1:0] attr_raw,
                                                          input logic [CellRowW-1:0] row,
                                                          input logic wide);
    logic [CharW-1:0]      chr;
    logic [AttrW-1:0]      attr;
    logic [CellW-1:0]      px;
    logic [2*CellW-1:0]    dbl;
    logic [GlyphWidth-1:0] glyph;
    logic                  rev, ul_row, lit;
    int                    band, idx;
    chr  = chr_raw;
    attr = attr_raw;
    px   = '0;
    dbl  = '0;
    // blank pairs
    if ((chr == ChrHigh && attr == AttrFour) || (chr == ChrNull && attr == AttrNone) ||
        (chr == ChrFour && attr == AttrFour)) begin
      chr  = ChrSpace;
      attr = AttrNone;
    end else if ((chr == ChrNull || chr == ChrFour) && attr == AttrRev) begin
      chr  = ChrSpace;
      attr = AttrRev;
    end
    if (chr != ChrNull && !chr[CharW-1]) begin
      rev    = attr[AttrRevBit];
      ul_row = attr[AttrUnderBit] && (row == GlyphHeight - 1);
      if (row < GlyphHeight) begin
        idx   = int'(chr[GlyphIdxW-1:0]) * GlyphHeight + int'(row);
        glyph = font_rows[idx];
        for (int c = 0; c < GlyphWidth; c++) begin
          lit = glyph[GlyphWidth-1-c] ^ rev;
          if (ul_row) lit = !rev;
          px[CellW-1-c] = lit;
        end
        px[0] = rev || ul_row;
      end
    end else if (row < GlyphHeight || (wide && row == GlyphHeight)) begin
      band = (row < MosaicMidRow) ? 0 : (row < MosaicBotRow) ? 2 : 4;
      for (int c = 0; c < GlyphWidth; c++) begin
        if (c < 2 * MosaicRightCol && row < MosaicEndRow)
          px[CellW-1-c] = chr[band + ((c >= MosaicRightCol) ? 1 : 0)];
      end
    end
    if (wide) return PixelRowW'(px);
    for (int c = 0; c < CellW; c++) dbl[2*c +: 2] = {2{px[c]}};
    return PixelRowW'(dbl);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q = 1'b1;
      pending_rows.delete();
      rows_pending_o <= 0;
    end else begin
      // a row returned now cannot belong to a request taken at this edge
      if (out_valid_i && out_ready_i) begin
        if (pending_rows.size() == 0) begin
          report_mismatch("nothing outstanding", pixel_row_i, '0);
        end else begin
          want_row = pending_rows.pop_front();
          if (pixel_row_i !== want_row) report_mismatch("pixel_row", pixel_row_i, want_row);
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (opcode_i == OpLoad) begin
          if (cell_row_i < GlyphHeight)
            font_rows[int'(char_code_i[GlyphIdxW-1:0]) * GlyphHeight + int'(cell_row_i)] =
              font_bits_i;
        end else begin
          pending_rows.push_back(cell_pixel_row(char_code_i, attr_code_i, cell_row_i, wide_q));
        end
      end
      if (cfg_valid_i && cfg_ready_i) wide_q = wide_mode_i;
      rows_pending_o <= pending_rows.size();
    end
  end

endmodule

// ----- tb/text_cell_row_generator_top_tb.sv -----
// ----------------------------------------------------------------------------
// text_cell_row_generator_top_tb
// Loads the whole font, runs a short directed set of render and load requests,
// then random phases in both column modes with random stalls on both sides.
// Rows are checked by text_cell_row_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module text_cell_row_generator_top_tb;
  import tcrg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GlyphWidth  = GlyphWidthDef;
  localparam int GlyphHeight = GlyphHeightDef;

  // Attribute values used by the directed requests
  localparam logic [AttrW-1:0] AttrUnder    = 8'h02;
  localparam logic [AttrW-1:0] AttrUnderRev = 8'h0a;
  localparam logic [AttrW-1:0] AttrAll      = 8'hff;

  localparam int IdlePct      = 38;   // chance of an idle cycle on either side
  localparam int PhaseCount   = 6;
  localparam int PhaseLength  = 140;  // random requests per phase
  localparam int HoldOff      = 6;    // covers the two-stage pipe after a load
  localparam int QuietLimit   = 1000; // cycles with no handshake at all

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic                  wide_mode   = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic                  opcode      = OpRender;
  logic [CharW-1:0]      char_code   = '0;
  logic [AttrW-1:0]      attr_code   = '0;
  logic [CellRowW-1:0]   cell_row    = '0;
  logic [GlyphWidth-1:0] font_bits   = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic [PixelRowW-1:0]  pixel_row;
  logic                  no_idle     = 1'b0;
  int                    rows_pending;
  int                    fail_count;
  int                    quiet       = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  text_cell_row_generator_top #(
    .GlyphWidth (GlyphWidth),
    .GlyphHeight(GlyphHeight)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .wide_mode_i(wide_mode),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .opcode_i   (opcode),
    .char_code_i(char_code),
    .attr_code_i(attr_code),
    .cell_row_i (cell_row),
    .font_bits_i(font_bits),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .pixel_row_o(pixel_row)
  );

  text_cell_row_checker #(
    .GlyphWidth (GlyphWidth),
    .GlyphHeight(GlyphHeight)
  ) rows_chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .wide_mode_i   (wide_mode),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .opcode_i      (opcode),
    .char_code_i   (char_code),
    .attr_code_i   (attr_code),
    .cell_row_i    (cell_row),
    .font_bits_i   (font_bits),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .pixel_row_i   (pixel_row),
    .rows_pending_o(rows_pending),
    .fail_count_o  (fail_count)
  );

  // Row sink: stalls at random, except through the no-idle stretch
  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= IdlePct);
  end

  // Watchdog: any handshake on any channel counts as progress
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet <= 0;
      end else if (quiet >= QuietLimit) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // One request on the input channel. Any idle gap comes first, so valid is
  // only raised at an edge where it was low or has just been accepted.
  task automatic send_request(input logic op, input logic [CharW-1:0] chr,
                              input logic [AttrW-1:0] attr, input logic [CellRowW-1:0] row,
                              input logic [GlyphWidth-1:0] bits);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    char_code <= chr;
    attr_code <= attr;
    cell_row  <= row;
    font_bits <= bits;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait for every outstanding row; the pending count is
  // registered, hence the first wait. The hold-off lets a trailing load
  // through the pipe before the mode may change.
  task automatic drain_rows();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
    repeat (HoldOff) @(posedge clk);
  endtask

  task automatic write_wide_mode(input logic wide);
    cfg_valid <= 1'b1;
    wide_mode <= wide;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random request: mostly renders, weighted towards text, mosaic and the
  // blank pairs, with clean attributes half the time.
  task automatic random_request();
    logic                  op;
    logic [CharW-1:0]      chr;
    logic [AttrW-1:0]      attr;
    logic [CellRowW-1:0]   row;
    logic [GlyphWidth-1:0] bits;
    int                    pick;
    op   = ($urandom_range(99) < 15) ? OpLoad : OpRender;
    chr  = CharW'($urandom);
    attr = AttrW'($urandom);
    row  = CellRowW'($urandom_range(GlyphHeight));
    bits = GlyphWidth'($urandom);
    if ($urandom_range(4) == 0) row = CellRowW'($urandom);
    if (op == OpRender) begin
      pick = $urandom_range(9);
      case (pick)
        0, 1, 2, 3: chr[CharW-1] = 1'b0;
        4, 5:       chr[CharW-1] = 1'b1;
        6: begin
          chr  = $urandom_range(1) ? ChrNull : ChrFour;
          attr = $urandom_range(1) ? AttrNone : AttrRev;
        end
        7: begin
          case ($urandom_range(4))
            0:       {chr, attr} = {ChrHigh, AttrFour};
            1:       {chr, attr} = {ChrNull, AttrNone};
            2:       {chr, attr} = {ChrFour, AttrFour};
            3:       {chr, attr} = {ChrNull, AttrRev};
            default: {chr, attr} = {ChrFour, AttrRev};
          endcase
        end
        default: ;
      endcase
      if (pick < 6 && $urandom_range(1) == 1) attr = attr & AttrUnderRev;
    end
    send_request(op, chr, attr, row, bits);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every glyph row gets written before any render can read it
    for (int g = 0; g < 128; g++) begin
      for (int r = 0; r < GlyphHeight; r++) begin
        send_request(OpLoad, {1'($urandom), 7'(g)}, AttrW'($urandom), CellRowW'(r),
                     GlyphWidth'($urandom));
      end
    end

    // Directed requests, in the wide mode left by reset
    send_request(OpRender, ChrHigh, AttrFour, 4'd0, '0);   // blank pairs
    send_request(OpRender, ChrNull, AttrNone, 4'd4, '0);
    send_request(OpRender, ChrFour, AttrFour, 4'd8, '0);
    send_request(OpRender, ChrNull, AttrRev, 4'd2, '0);
    send_request(OpRender, ChrFour, AttrRev, 4'd9, '0);
    send_request(OpRender, ChrHigh, AttrNone, 4'd0, '0);   // near misses
    send_request(OpRender, ChrFour, AttrNone, 4'd3, '0);
    send_request(OpRender, ChrNull, AttrFour, 4'd7, '0);
    send_request(OpRender, 8'h01, AttrNone, 4'd0, '0);     // text extremes
    send_request(OpRender, 8'h7f, AttrUnder, 4'd8, '0);
    send_request(OpRender, 8'h7f, AttrRev, 4'd8, '0);
    send_request(OpRender, 8'h7f, AttrUnderRev, 4'd8, '0);
    send_request(OpRender, 8'h7f, AttrUnderRev, 4'd9, '0);
    send_request(OpRender, 8'h41, AttrAll, 4'd15, '0);
    send_request(OpRender, 8'hff, AttrNone, 4'd0, '0);     // mosaic
    send_request(OpRender, 8'hff, AttrNone, 4'd9, '0);
    send_request(OpRender, 8'hff, AttrAll, 4'd15, '0);
    send_request(OpRender, 8'hbf, AttrNone, 4'd5, '0);     // the formerly skipped code
    send_request(OpRender, 8'haa, AttrNone, 4'd7, '0);
    send_request(OpLoad, 8'hc1, AttrAll, 4'd3, 5'h15);     // load then read straight back
    send_request(OpRender, 8'h41, AttrNone, 4'd3, '0);
    send_request(OpLoad, 8'h41, AttrNone, 4'd9, 5'h1f);    // loads past the glyph are dropped
    send_request(OpLoad, 8'h41, AttrNone, 4'd15, 5'h00);
    send_request(OpRender, 8'h41, AttrUnder, 4'd8, '0);
    drain_rows();

    // Random phases alternating narrow and wide; the sender waits for every
    // row at each boundary before the mode changes
    for (int p = 0; p < PhaseCount; p++) begin
      write_wide_mode(p[0]);
      no_idle <= (p == 2);
      repeat (PhaseLength) random_request();
      drain_rows();
    end
    no_idle <= 1'b0;

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
